[hw/rtl/wor_pkg.sv]
`default_nettype none

package wor_pkg;

  // Widths of the id, its fields and the configuration values.
  localparam int ID_BITS         = 16;
  localparam int CNT_BITS        = 12;
  localparam int MODE_BITS       = 5;
  localparam int TPG_BITS        = 5;
  localparam int CHUNK_BITS      = 5;
  localparam int MAC_BITS        = ID_BITS - CHUNK_BITS;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = CNT_BITS;

  // Stages of the streaming divider, one quotient bit each.
  localparam int DIV_STAGES      = ID_BITS;

  // Iterations of the M-group count divider.
  localparam int NG_DIV_BITS     = CNT_BITS + 1;
  localparam int NG_CNT_BITS     = $clog2(NG_DIV_BITS);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ORDER_MODE      = 2'd0,
    CFG_TILES_M         = 2'd1,
    CFG_TILES_N         = 2'd2,
    CFG_TILES_PER_GROUP = 2'd3
  } cfg_index_e;

  // Ordering modes. Codes that are not listed pass the id through.
  localparam logic [MODE_BITS-1:0] MODE_R4X8_NF   = 5'd1;
  localparam logic [MODE_BITS-1:0] MODE_R4X8_MF   = 5'd2;
  localparam logic [MODE_BITS-1:0] MODE_R8X4_NF   = 5'd3;
  localparam logic [MODE_BITS-1:0] MODE_R8X4_MF   = 5'd4;
  localparam logic [MODE_BITS-1:0] MODE_NMAJOR    = 5'd5;
  localparam logic [MODE_BITS-1:0] MODE_SW16      = 5'd6;
  localparam logic [MODE_BITS-1:0] MODE_SW8       = 5'd7;
  localparam logic [MODE_BITS-1:0] MODE_SW4       = 5'd8;
  localparam logic [MODE_BITS-1:0] MODE_XOR_LM    = 5'd11;
  localparam logic [MODE_BITS-1:0] MODE_XOR_LM15  = 5'd12;
  localparam logic [MODE_BITS-1:0] MODE_GRAY      = 5'd13;
  localparam logic [MODE_BITS-1:0] MODE_XOR_MAC   = 5'd14;
  localparam logic [MODE_BITS-1:0] MODE_SPLIT1    = 5'd15;
  localparam logic [MODE_BITS-1:0] MODE_SPLIT2    = 5'd16;
  localparam logic [MODE_BITS-1:0] MODE_SPLIT3    = 5'd17;
  localparam logic [MODE_BITS-1:0] MODE_REV       = 5'd18;
  localparam logic [MODE_BITS-1:0] MODE_ROT1      = 5'd19;
  localparam logic [MODE_BITS-1:0] MODE_ROT2      = 5'd20;
  localparam logic [MODE_BITS-1:0] MODE_ROT3      = 5'd21;

  // Shape conditions derived from the configuration.
  typedef struct packed {
    logic even_4x8;
    logic even_8x4;
    logic has_groups;
    logic exact;
  } shape_t;

endpackage

`default_nettype wire

[hw/rtl/workgroup_order_remap_top.sv]
`default_nettype none

// A result passes through the input stage, the 16-stage streaming divider and
// the compose, multiply and output stages.
// Throughput: one item per cycle while no M-group count divide is running; a
// stalled output holds the whole pipeline. After any configuration write the
// input is held off while the M-group count is divided out one bit per cycle.
// Reset: registers take their reset values and the pipeline is empty.
module workgroup_order_remap_top
  import wor_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Configuration write channel.
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  // Input items.
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [ID_BITS-1:0]        s_axis_tdata,   // [15:0] dispatch_id
  // Result items.
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [ID_BITS-1:0]             m_axis_tdata,   // [15:0] logical_id
  output logic                           m_axis_tuser    // [0] remap_applied
);

  // Configuration registers.
  logic [MODE_BITS-1:0] order_mode_q;
  logic [CNT_BITS-1:0]  tiles_m_q;
  logic [CNT_BITS-1:0]  tiles_n_q;
  logic [TPG_BITS-1:0]  tiles_per_group_q;
  logic                 cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q      <= '0;
      tiles_m_q         <= CNT_BITS'(1);
      tiles_n_q         <= CNT_BITS'(1);
      tiles_per_group_q <= TPG_BITS'(1);
    end else if (cfg_fire) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ORDER_MODE:      order_mode_q      <= cfg_data_i[MODE_BITS-1:0];
        CFG_TILES_M:         tiles_m_q         <= cfg_data_i[CNT_BITS-1:0];
        CFG_TILES_N:         tiles_n_q         <= cfg_data_i[CNT_BITS-1:0];
        CFG_TILES_PER_GROUP: tiles_per_group_q <= cfg_data_i[TPG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // M-group count: ceil(tiles_m / tiles_per_group), one quotient bit a cycle.
  logic [TPG_BITS-1:0]    tpg_eff;
  logic [NG_DIV_BITS-1:0] ng_dividend;
  logic                   ng_start_q;
  logic                   ng_busy_q;
  logic [NG_CNT_BITS-1:0] ng_cnt_q;
  logic [TPG_BITS-1:0]    ng_rem_q;
  logic [NG_DIV_BITS-1:0] ng_x_q;
  logic [CNT_BITS-1:0]    ng_q;
  logic [TPG_BITS:0]      ng_trial;
  logic                   ng_ge;
  logic [TPG_BITS-1:0]    ng_rem_d;
  logic [NG_DIV_BITS-1:0] ng_x_d;

  assign tpg_eff     = (tiles_per_group_q == '0) ? TPG_BITS'(1) : tiles_per_group_q;
  assign ng_dividend = NG_DIV_BITS'(tiles_m_q) + NG_DIV_BITS'(tpg_eff)
                       - NG_DIV_BITS'(1);

  always_comb begin
    ng_trial = {ng_rem_q, ng_x_q[NG_DIV_BITS-1]};
    ng_ge    = ng_trial >= {1'b0, tpg_eff};
    ng_rem_d = ng_ge ? TPG_BITS'(ng_trial - {1'b0, tpg_eff})
                     : ng_trial[TPG_BITS-1:0];
    ng_x_d   = {ng_x_q[NG_DIV_BITS-2:0], ng_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ng_start_q <= 1'b0;
      ng_busy_q  <= 1'b0;
      ng_cnt_q   <= '0;
      ng_q       <= CNT_BITS'(1);
    end else if (cfg_fire) begin
      ng_start_q <= 1'b1;
      ng_busy_q  <= 1'b1;
    end else if (ng_start_q) begin
      ng_start_q <= 1'b0;
      ng_cnt_q   <= '0;
    end else if (ng_busy_q) begin
      ng_cnt_q <= ng_cnt_q + NG_CNT_BITS'(1);
      if (ng_cnt_q == NG_CNT_BITS'(NG_DIV_BITS - 1)) begin
        ng_busy_q <= 1'b0;
        ng_q      <= ng_x_d[CNT_BITS-1:0];
      end
    end
  end

  // Divider datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    if (ng_start_q) begin
      ng_rem_q <= '0;
      ng_x_q   <= ng_dividend;
    end else if (ng_busy_q) begin
      ng_rem_q <= ng_rem_d;
      ng_x_q   <= ng_x_d;
    end
  end

  // Shape conditions and the divisor of the streaming divider.
  shape_t              shape;
  logic [CNT_BITS-1:0] div_d;
  logic                mode_nmajor;

  always_comb begin
    shape.even_4x8   = (ng_q[1:0] == 2'd0) && (tiles_n_q[2:0] == 3'd0)
                       && (tiles_n_q != '0);
    shape.even_8x4   = (ng_q[2:0] == 3'd0) && (tiles_n_q[1:0] == 2'd0)
                       && (tiles_n_q != '0);
    shape.has_groups = ng_q != '0;
    shape.exact      = (ng_q == CNT_BITS'(8)) && (tiles_n_q == CNT_BITS'(32));
  end

  assign mode_nmajor = order_mode_q == MODE_NMAJOR;

  always_comb begin
    case (order_mode_q) inside
      MODE_R4X8_NF, MODE_R4X8_MF: div_d = tiles_n_q >> 3;
      MODE_R8X4_NF, MODE_R8X4_MF: div_d = tiles_n_q >> 2;
      default:                    div_d = ng_q;
    endcase
  end

  // Pipeline advance: everything moves unless a result waits at the output.
  logic out_valid_q;
  logic adv;
  logic s_fire;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv && !ng_busy_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Input stage.
  logic               in_valid_q;
  logic [ID_BITS-1:0] in_pid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_pid_q <= s_axis_tdata;
    end
  end

  // Streaming divider: chunk index (or id in N-major mode) by the divisor.
  logic [DIV_STAGES-1:0] dv_valid_q;
  logic [CNT_BITS-1:0]   dv_rem_q [DIV_STAGES];
  logic [ID_BITS-1:0]    dv_x_q   [DIV_STAGES];
  logic [ID_BITS-1:0]    dv_pid_q [DIV_STAGES];
  logic [ID_BITS-1:0]    dv_first_x;

  assign dv_first_x = mode_nmajor ? in_pid_q
                                  : ID_BITS'(in_pid_q[ID_BITS-1:CHUNK_BITS]);

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [CNT_BITS-1:0] rem_in;
    logic [ID_BITS-1:0]  x_in;
    logic [ID_BITS-1:0]  pid_in;
    logic                valid_in;
    logic [CNT_BITS:0]   trial;
    logic                ge;
    logic [CNT_BITS-1:0] rem_d;
    logic [ID_BITS-1:0]  x_d;

    if (s == 0) begin : g_head
      assign rem_in   = '0;
      assign x_in     = dv_first_x;
      assign pid_in   = in_pid_q;
      assign valid_in = in_valid_q;
    end else begin : g_body
      assign rem_in   = dv_rem_q[s-1];
      assign x_in     = dv_x_q[s-1];
      assign pid_in   = dv_pid_q[s-1];
      assign valid_in = dv_valid_q[s-1];
    end

    // One restoring step: shift in a dividend bit, subtract if it fits.
    always_comb begin
      trial = {rem_in, x_in[ID_BITS-1]};
      ge    = trial >= {1'b0, div_d};
      rem_d = ge ? CNT_BITS'(trial - {1'b0, div_d}) : trial[CNT_BITS-1:0];
      x_d   = {x_in[ID_BITS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[s] <= 1'b0;
      end else if (adv) begin
        dv_valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[s] <= rem_d;
        dv_x_q[s]   <= x_d;
        dv_pid_q[s] <= pid_in;
      end
    end
  end

  // Compose stage: M-group and N tile per mode.
  logic [ID_BITS-1:0]    qt;
  logic [CNT_BITS-1:0]   rm;
  logic [ID_BITS-1:0]    cp_pid;
  logic [MAC_BITS-1:0]   mac;
  logic [CHUNK_BITS-1:0] loc;
  logic                  lm;
  logic [3:0]            rn;
  logic [3:0]            pn;
  logic [ID_BITS-1:0]    mg_d;
  logic [ID_BITS-1:0]    n_d;
  logic                  ok_d;

  assign qt     = dv_x_q[DIV_STAGES-1];
  assign rm     = dv_rem_q[DIV_STAGES-1];
  assign cp_pid = dv_pid_q[DIV_STAGES-1];
  assign mac    = cp_pid[ID_BITS-1:CHUNK_BITS];
  assign loc    = cp_pid[CHUNK_BITS-1:0];

  // Local M bit and remaining N bits of the swizzle modes.
  always_comb begin
    case (order_mode_q)
      MODE_SPLIT1: begin
        lm = loc[1];
        rn = {loc[4:2], loc[0]};
      end
      MODE_SPLIT2: begin
        lm = loc[2];
        rn = {loc[4:3], loc[1:0]};
      end
      MODE_SPLIT3: begin
        lm = loc[3];
        rn = {loc[4], loc[2:0]};
      end
      default: begin
        lm = loc[4];
        rn = loc[3:0];
      end
    endcase
  end

  // Permutation of the N bits.
  always_comb begin
    case (order_mode_q)
      MODE_XOR_LM:   pn = rn ^ {lm, 3'b000};
      MODE_XOR_LM15: pn = rn ^ {4{lm}};
      MODE_GRAY:     pn = rn ^ (rn >> 1);
      MODE_XOR_MAC:  pn = rn ^ {mac[1], 3'b000};
      MODE_REV:      pn = {rn[0], rn[1], rn[2], rn[3]};
      MODE_ROT1:     pn = {rn[2:0], rn[3]};
      MODE_ROT2:     pn = {rn[1:0], rn[3:2]};
      MODE_ROT3:     pn = {rn[0], rn[3:1]};
      default:       pn = rn;
    endcase
  end

  always_comb begin
    mg_d = '0;
    n_d  = '0;
    ok_d = 1'b0;
    unique case (order_mode_q) inside
      MODE_R4X8_NF: begin
        mg_d = ID_BITS'({qt, loc[4:3]});
        n_d  = ID_BITS'({rm, loc[2:0]});
        ok_d = shape.even_4x8;
      end
      MODE_R4X8_MF: begin
        mg_d = ID_BITS'({qt, loc[1:0]});
        n_d  = ID_BITS'({rm, loc[4:2]});
        ok_d = shape.even_4x8;
      end
      MODE_R8X4_NF: begin
        mg_d = ID_BITS'({qt, loc[4:2]});
        n_d  = ID_BITS'({rm, loc[1:0]});
        ok_d = shape.even_8x4;
      end
      MODE_R8X4_MF: begin
        mg_d = ID_BITS'({qt, loc[2:0]});
        n_d  = ID_BITS'({rm, loc[4:3]});
        ok_d = shape.even_8x4;
      end
      MODE_NMAJOR: begin
        mg_d = ID_BITS'(rm);
        n_d  = qt;
        ok_d = shape.has_groups;
      end
      MODE_SW16: begin
        mg_d = ID_BITS'({mac[MAC_BITS-1:1], loc[4]});
        n_d  = ID_BITS'({mac[0], loc[3:0]});
        ok_d = shape.exact;
      end
      MODE_SW8: begin
        mg_d = ID_BITS'({mac[MAC_BITS-1:2], loc[4:3]});
        n_d  = ID_BITS'({mac[1:0], loc[2:0]});
        ok_d = shape.exact;
      end
      MODE_SW4: begin
        mg_d = ID_BITS'(loc[4:2]);
        n_d  = ID_BITS'({mac, loc[1:0]});
        ok_d = shape.exact;
      end
      MODE_XOR_LM, MODE_XOR_LM15, MODE_GRAY, MODE_XOR_MAC, MODE_SPLIT1,
      MODE_SPLIT2, MODE_SPLIT3, MODE_REV, MODE_ROT1, MODE_ROT2, MODE_ROT3: begin
        mg_d = ID_BITS'({mac[MAC_BITS-1:1], lm});
        n_d  = ID_BITS'({mac[0], pn});
        ok_d = shape.exact;
      end
      default: ;
    endcase
  end

  logic               cm_valid_q;
  logic [ID_BITS-1:0] cm_mg_q;
  logic [ID_BITS-1:0] cm_n_q;
  logic [ID_BITS-1:0] cm_pid_q;
  logic               cm_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_valid_q <= 1'b0;
    end else if (adv) begin
      cm_valid_q <= dv_valid_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cm_mg_q  <= mg_d;
      cm_n_q   <= n_d;
      cm_pid_q <= cp_pid;
      cm_ok_q  <= ok_d;
    end
  end

  // Multiply stage: M-group times tiles_n, kept to the id width.
  logic [ID_BITS-1:0] prod_lo;
  logic               ml_valid_q;
  logic [ID_BITS-1:0] ml_prod_q;
  logic [ID_BITS-1:0] ml_n_q;
  logic [ID_BITS-1:0] ml_pid_q;
  logic               ml_ok_q;

  assign prod_lo = cm_mg_q * ID_BITS'(tiles_n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ml_valid_q <= 1'b0;
    end else if (adv) begin
      ml_valid_q <= cm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ml_prod_q <= prod_lo;
      ml_n_q    <= cm_n_q;
      ml_pid_q  <= cm_pid_q;
      ml_ok_q   <= cm_ok_q;
    end
  end

  // Output stage: add the N tile or pass the id through.
  logic [ID_BITS-1:0] out_id_q;
  logic               out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ml_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_id_q <= ml_ok_q ? (ml_prod_q + ml_n_q) : ml_pid_q;
      out_ok_q <= ml_ok_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_id_q;
  assign m_axis_tuser  = out_ok_q;

endmodule

`default_nettype wire
